/* rtl/merge_two_sorted_lists_core_macros.svh */
// ----------------------------------------------------------------------------
// merge_two_sorted_lists_core assertion macros
// Concurrent property checks, compiled away when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef MERGE_TWO_SORTED_LISTS_CORE_MACROS_SVH
`define MERGE_TWO_SORTED_LISTS_CORE_MACROS_SVH

`ifndef SYNTH

// same-cycle implication
`define MTSL_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define MTSL_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`else

`define MTSL_ASSERT_IMP(label, clk, rst, ante, cons, msg)
`define MTSL_ASSERT_NEXT(label, clk, rst, ante, cons, msg)

`endif

`endif

/* rtl/mtsl_pkg.sv */
// ----------------------------------------------------------------------------
// mtsl_pkg
// Shared types, codes and defaults for the sorted-list merge block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package mtsl_pkg;

   // default configuration
   localparam int DEPTH_DEF      = 32;
   localparam int DATA_WIDTH_DEF = 32;

   // fixed field widths
   localparam int OP_W     = 2;
   localparam int VALUE_W  = 32;
   localparam int STATUS_W = 2;

   // operation codes
   localparam logic [OP_W-1:0] OP_APPEND_A = 2'd0;
   localparam logic [OP_W-1:0] OP_APPEND_B = 2'd1;
   localparam logic [OP_W-1:0] OP_MERGE    = 2'd2;

   // result status codes
   localparam logic [STATUS_W-1:0] STAT_ELEM  = 2'd0;
   localparam logic [STATUS_W-1:0] STAT_EMPTY = 2'd1;
   localparam logic [STATUS_W-1:0] STAT_FULL  = 2'd2;

   typedef struct packed {
      logic [OP_W-1:0]           operation;
      logic signed [VALUE_W-1:0] value;
   } req_type;

   typedef struct packed {
      logic signed [VALUE_W-1:0] value_out;
      logic [STATUS_W-1:0]       status;
      logic                      last;
   } rsp_type;

   typedef enum logic {
      ST_IDLE,
      ST_MERGE
   } state_type;

   typedef enum logic [1:0] {
      KIND_ELEM,
      KIND_EMPTY,
      KIND_FULL
   } out_kind_type;

   // controller to datapath
   typedef struct packed {
      logic         push_a;
      logic         push_b;
      logic         pop;
      logic         take_a;
      logic         clear;
      logic         load_out;
      out_kind_type out_kind;
      logic         out_last;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic full_a;
      logic full_b;
      logic empty_all;
      logic left_a;
      logic left_b;
      logic a_lt_b;
      logic final_pick;
      logic out_free;
   } stat_type;

endpackage

`default_nettype wire

/* rtl/mtsl_ctrl.sv */
// ----------------------------------------------------------------------------
// mtsl_ctrl
// Controller: decodes operations and sequences the merge, one pick per cycle while the output register is free.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module mtsl_ctrl
   import mtsl_pkg::*;
(
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            req_valid,
   input  wire logic [OP_W-1:0] req_operation,
   output logic                 req_stall,
   input  wire stat_type        stat,
   output cmd_type              cmd
);

   state_type state_ff;
   state_type state_in;

   // hold state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state and commands
   always_comb begin
      state_in     = state_ff;
      req_stall    = 1'b1;
      cmd          = '0;
      cmd.out_kind = KIND_ELEM;
      unique case (state_ff)
         ST_IDLE: begin
            req_stall = !stat.out_free;
            if (req_valid && stat.out_free) begin
               unique case (req_operation)
                  OP_APPEND_A: begin
                     if (stat.full_a) begin
                        cmd.load_out = 1'b1;
                        cmd.out_kind = KIND_FULL;
                        cmd.out_last = 1'b1;
                     end else begin
                        cmd.push_a = 1'b1;
                     end
                  end
                  OP_APPEND_B: begin
                     if (stat.full_b) begin
                        cmd.load_out = 1'b1;
                        cmd.out_kind = KIND_FULL;
                        cmd.out_last = 1'b1;
                     end else begin
                        cmd.push_b = 1'b1;
                     end
                  end
                  OP_MERGE: begin
                     if (stat.empty_all) begin
                        cmd.load_out = 1'b1;
                        cmd.out_kind = KIND_EMPTY;
                        cmd.out_last = 1'b1;
                     end else begin
                        state_in = ST_MERGE;
                     end
                  end
                  default: begin
                     // unused code: drop
                  end
               endcase
            end
         end
         ST_MERGE: begin
            // advance one pick whenever the output register can take it
            if (stat.out_free) begin
               cmd.pop      = 1'b1;
               cmd.take_a   = stat.left_a && (!stat.left_b || stat.a_lt_b);
               cmd.load_out = 1'b1;
               cmd.out_kind = KIND_ELEM;
               cmd.out_last = stat.final_pick;
               if (stat.final_pick) begin
                  cmd.clear = 1'b1;
                  state_in  = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

`default_nettype wire

/* rtl/mtsl_dp.sv */
// ----------------------------------------------------------------------------
// mtsl_dp
// Datapath: the two element stores, their counts and read pointers, the head
// compare and the result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module mtsl_dp
   import mtsl_pkg::*;
#(
   parameter int DEPTH      = DEPTH_DEF,
   parameter int DATA_WIDTH = DATA_WIDTH_DEF
)(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic [VALUE_W-1:0] req_value,
   input  wire cmd_type            cmd,
   output stat_type                stat,
   output logic                    rsp_valid,
   input  wire logic               rsp_stall,
   output rsp_type                 rsp_data
);

   localparam int ElemW = (DATA_WIDTH < VALUE_W) ? DATA_WIDTH : VALUE_W;
   localparam int CntW  = $clog2(DEPTH + 1);
   localparam int IdxW  = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   logic [ElemW-1:0] mem_a [DEPTH];
   logic [ElemW-1:0] mem_b [DEPTH];

   logic [CntW-1:0]  cnt_a_ff, cnt_a_in;
   logic [CntW-1:0]  cnt_b_ff, cnt_b_in;
   logic [CntW-1:0]  ia_ff, ia_in;
   logic [CntW-1:0]  ib_ff, ib_in;
   logic [ElemW-1:0] head_a_ff;
   logic [ElemW-1:0] head_b_ff;
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_type          rsp_ff, rsp_in;
   logic [CntW:0]    picked_sum;
   logic [CntW:0]    held_sum;
   logic [ElemW-1:0] pick;

   // counts and read pointers
   always_comb begin
      cnt_a_in = cnt_a_ff;
      cnt_b_in = cnt_b_ff;
      ia_in    = ia_ff;
      ib_in    = ib_ff;
      if (cmd.clear) begin
         cnt_a_in = '0;
         cnt_b_in = '0;
         ia_in    = '0;
         ib_in    = '0;
      end else begin
         if (cmd.push_a) begin
            cnt_a_in = cnt_a_ff + 1'b1;
         end
         if (cmd.push_b) begin
            cnt_b_in = cnt_b_ff + 1'b1;
         end
         if (cmd.pop && cmd.take_a) begin
            ia_in = ia_ff + 1'b1;
         end
         if (cmd.pop && !cmd.take_a) begin
            ib_in = ib_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_a_ff <= '0;
         cnt_b_ff <= '0;
         ia_ff    <= '0;
         ib_ff    <= '0;
      end else begin
         cnt_a_ff <= cnt_a_in;
         cnt_b_ff <= cnt_b_in;
         ia_ff    <= ia_in;
         ib_ff    <= ib_in;
      end
   end

   // store A: append at the tail, read the next head
   always_ff @(posedge clock) begin
      if (cmd.push_a) begin
         mem_a[cnt_a_ff[IdxW-1:0]] <= req_value[ElemW-1:0];
      end
      head_a_ff <= mem_a[ia_in[IdxW-1:0]];
   end

   // store B: append at the tail, read the next head
   always_ff @(posedge clock) begin
      if (cmd.push_b) begin
         mem_b[cnt_b_ff[IdxW-1:0]] <= req_value[ElemW-1:0];
      end
      head_b_ff <= mem_b[ib_in[IdxW-1:0]];
   end

   // status toward the controller
   assign picked_sum = {1'b0, ia_ff} + {1'b0, ib_ff} + 1'b1;
   assign held_sum   = {1'b0, cnt_a_ff} + {1'b0, cnt_b_ff};

   always_comb begin
      stat            = '0;
      stat.full_a     = (cnt_a_ff == CntW'(DEPTH));
      stat.full_b     = (cnt_b_ff == CntW'(DEPTH));
      stat.empty_all  = (cnt_a_ff == '0) && (cnt_b_ff == '0);
      stat.left_a     = (ia_ff != cnt_a_ff);
      stat.left_b     = (ib_ff != cnt_b_ff);
      stat.a_lt_b     = ($signed(head_a_ff) < $signed(head_b_ff));
      stat.final_pick = (picked_sum == held_sum);
      stat.out_free   = !rsp_valid_ff || !rsp_stall;
   end

   // result register: load on command, drop after transfer
   assign pick = cmd.take_a ? head_a_ff : head_b_ff;

   always_comb begin
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (cmd.load_out) begin
         rsp_valid_in = 1'b1;
         rsp_in.last  = cmd.out_last;
         unique case (cmd.out_kind)
            KIND_ELEM: begin
               rsp_in.value_out = VALUE_W'($signed(pick));
               rsp_in.status    = STAT_ELEM;
            end
            KIND_EMPTY: begin
               rsp_in.value_out = '0;
               rsp_in.status    = STAT_EMPTY;
            end
            KIND_FULL: begin
               rsp_in.value_out = '0;
               rsp_in.status    = STAT_FULL;
            end
            default: begin
               rsp_in.value_out = '0;
               rsp_in.status    = STAT_ELEM;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

`default_nettype wire

/* rtl/merge_two_sorted_lists_core.sv */
// ----------------------------------------------------------------------------
// merge_two_sorted_lists_core
// Merges two ascending lists of signed elements held in two bounded stores.
//
// Usage: the req channel carries an operation and a value. Append to A or B
// writes the value at the tail of that store and gives no result; an append
// to a full store gives one result with status full. Merge emits every held
// element in ascending order on the rsp channel (on equal heads the B element
// goes first) and empties both stores; merging two empty stores gives one
// result with status empty. The last result of each run has last set.
// Timing: a merge holds req stalled while it emits one element per cycle
// when rsp is not stalled; the first element passes the state register,
// which enters the merge state, and then the output register. Results pass
// through one output register; a new request is taken only once the held
// result transfers, at the latest in the same cycle. When rsp is stalled,
// req is stalled as well, picking pauses and the held result stays unchanged.
// Reset empties both stores and clears the output valid; store contents
// are not cleared and are never used before being written.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "merge_two_sorted_lists_core_macros.svh"

module merge_two_sorted_lists_core
   import mtsl_pkg::*;
#(
   parameter int DEPTH      = DEPTH_DEF,
   parameter int DATA_WIDTH = DATA_WIDTH_DEF
)(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_stall,
   input  wire req_type req_data,
   output logic         rsp_valid,
   input  wire logic    rsp_stall,
   output rsp_type      rsp_data
);

   cmd_type  cmd;
   stat_type stat;

   // controller
   mtsl_ctrl u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_operation (req_data.operation),
      .req_stall     (req_stall),
      .stat          (stat),
      .cmd           (cmd)
   );

   // datapath
   mtsl_dp #(
      .DEPTH      (DEPTH),
      .DATA_WIDTH (DATA_WIDTH)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_value (req_data.value),
      .cmd       (cmd),
      .stat      (stat),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   // checks
   `MTSL_ASSERT_IMP(a_no_overwrite, clock, reset, cmd.load_out, !(rsp_valid && rsp_stall), "result overwritten while stalled")
   `MTSL_ASSERT_IMP(a_status_last, clock, reset, rsp_valid && (rsp_data.status != STAT_ELEM), rsp_data.last, "status result without last")
   `MTSL_ASSERT_IMP(a_no_req_in_merge, clock, reset, cmd.pop, req_stall, "request taken during merge")
   `MTSL_ASSERT_NEXT(a_clear_empties, clock, reset, cmd.clear, stat.empty_all, "stores not empty after merge")

endmodule

`default_nettype wire
